[rtl/scba_pkg.sv]
// shared types, codes and default sizes for the size class block allocator
package scba_pkg;

  localparam int POOL_PAGES_DEF   = 64;
  localparam int PAGE_BYTES_DEF   = 4096;
  localparam int TOP_LEVEL_DEF    = 12;
  localparam int HEADER_BYTES_DEF = 16;

  localparam int ADDR_W = 18;
  localparam int REQ_W  = 13;
  localparam int CFG_W  = 7;
  localparam logic [CFG_W-1:0] PAGES_ENABLED_RST = 7'd64;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_BIG   = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_BAD   = 2'd3;

  typedef struct packed {
    logic              func;
    logic [REQ_W-1:0]  req_size;
    logic [ADDR_W-1:0] free_addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] block_addr;
    logic [1:0]        status;
  } rsp_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
  } link_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_REFILL,
    ST_POP,
    ST_LINK,
    ST_FREE_PUSH,
    ST_FINISH
  } st_t;

  typedef struct packed {
    logic       clr_we;
    logic       latch;
    logic       take_tag_lvl;
    logic       refill_init;
    logic       refill_push;
    logic       pop_read;
    logic       pop_commit;
    logic       free_push;
    logic       res_set;
    logic [1:0] res_status;
    logic       rsp_load;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic big;
    logic head_valid;
    logic pages_full;
    logic free_ok;
    logic refill_last;
    logic clr_last;
    logic rsp_busy;
  } stat_t;

endpackage

[rtl/scba_ctrl.sv]
// controller state machine for the size class block allocator
module scba_ctrl import scba_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  st_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:     if (stat.clr_last) state_next = ST_IDLE;
      ST_IDLE:      if (req_valid) state_next = ST_DECODE;
      ST_DECODE: begin
        if (stat.is_free) begin
          state_next = stat.free_ok ? ST_FREE_PUSH : ST_FINISH;
        end else if (stat.big) begin
          state_next = ST_FINISH;
        end else if (stat.head_valid) begin
          state_next = ST_POP;
        end else if (stat.pages_full) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_REFILL;
        end
      end
      ST_REFILL:    if (stat.refill_last) state_next = ST_POP;
      ST_POP:       state_next = ST_LINK;
      ST_LINK:      state_next = ST_FINISH;
      ST_FREE_PUSH: state_next = ST_FINISH;
      ST_FINISH:    if (!stat.rsp_busy) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.res_status = STAT_OK;
    req_stall = 1'b1;
    case (state)
      ST_CLEAR: cmd.clr_we = 1'b1;
      ST_IDLE: begin
        req_stall = 1'b0;
        cmd.latch = req_valid;
      end
      ST_DECODE: begin
        if (stat.is_free) begin
          if (stat.free_ok) begin
            cmd.take_tag_lvl = 1'b1;
          end else begin
            cmd.res_set = 1'b1;
            cmd.res_status = STAT_BAD;
          end
        end else if (stat.big) begin
          cmd.res_set = 1'b1;
          cmd.res_status = STAT_BIG;
        end else if (!stat.head_valid) begin
          if (stat.pages_full) begin
            cmd.res_set = 1'b1;
            cmd.res_status = STAT_EMPTY;
          end else begin
            cmd.refill_init = 1'b1;
          end
        end
      end
      ST_REFILL: cmd.refill_push = 1'b1;
      ST_POP:    cmd.pop_read = 1'b1;
      ST_LINK: begin
        cmd.pop_commit = 1'b1;
        cmd.res_set = 1'b1;
      end
      ST_FREE_PUSH: begin
        cmd.free_push = 1'b1;
        cmd.res_set = 1'b1;
      end
      ST_FINISH: cmd.rsp_load = !stat.rsp_busy;
      default: ;
    endcase
  end

endmodule

[rtl/scba_dp.sv]
// datapath: class heads, link and tag memories, refill counters, result register
module scba_dp import scba_pkg::*; #(
  parameter int POOL_PAGES   = POOL_PAGES_DEF,
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int TOP_LEVEL    = TOP_LEVEL_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  req_t             req,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  input  cmd_t             cmd,
  output stat_t            stat,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp
);

  localparam int MIN_SHIFT  = $clog2(HEADER_BYTES);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int POOL_BYTES = POOL_PAGES * PAGE_BYTES;
  localparam int SLOTS      = POOL_BYTES >> MIN_SHIFT;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int LVL_W      = $clog2(TOP_LEVEL + 1);
  localparam int PG_W       = $clog2(POOL_PAGES + 1);
  localparam int CNT_W      = PAGE_SHIFT - MIN_SHIFT;
  localparam int SZ_W       = REQ_W + 1;

  link_t heads [TOP_LEVEL+1];
  link_t links [SLOTS];
  logic [LVL_W:0] tags [SLOTS];

  logic [CFG_W-1:0]  pages_enabled;
  logic [PG_W-1:0]   pages_used;
  logic [SLOT_W-1:0] clr_cnt;
  logic              func_r;
  logic              big;
  logic [LVL_W-1:0]  cur_lvl;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] blk;
  logic [CNT_W-1:0]  cnt;
  logic [LVL_W:0]    tag_rd;
  link_t             link_rd;
  rsp_t              res;

  logic [31:0]       size32;
  logic [4:0]        lvl_in;
  logic              big_in;
  logic [ADDR_W-1:0] fbase;
  logic [SLOT_W-1:0] slot_in;
  logic [SLOT_W-1:0] slot_base;
  logic [SLOT_W-1:0] slot_blk;
  logic [SLOT_W-1:0] slot_head;
  link_t             head_cur;
  logic              rsp_busy;

  // smallest class that holds header plus request
  always_comb begin
    size32 = 32'(req.req_size) + 32'(HEADER_BYTES);
    lvl_in = 5'(SZ_W);
    for (int l = SZ_W; l >= 0; l--) begin
      if ((32'd1 << l) >= size32) lvl_in = 5'(l);
    end
    big_in = (size32 > 32'(PAGE_BYTES)) || (32'(lvl_in) > 32'(TOP_LEVEL))
          || (32'(lvl_in) > 32'(PAGE_SHIFT));
  end

  assign fbase     = req.free_addr - ADDR_W'(HEADER_BYTES);
  assign slot_in   = SLOT_W'(32'(fbase) >> MIN_SHIFT);
  assign slot_base = SLOT_W'(32'(base) >> MIN_SHIFT);
  assign slot_blk  = SLOT_W'(32'(blk) >> MIN_SHIFT);
  assign head_cur  = heads[cur_lvl];
  assign slot_head = SLOT_W'(32'(head_cur.addr) >> MIN_SHIFT);
  assign rsp_busy  = rsp_valid && rsp_stall;

  always_comb begin
    stat.is_free     = func_r == FUNC_FREE;
    stat.big         = big;
    stat.head_valid  = head_cur.valid;
    stat.pages_full  = (32'(pages_used) >= 32'(pages_enabled))
                    || (32'(pages_used) >= 32'(POOL_PAGES));
    stat.free_ok     = (32'(base) < 32'(POOL_BYTES))
                    && ((32'(base) & ((32'd1 << MIN_SHIFT) - 32'd1)) == 32'd0)
                    && tag_rd[LVL_W] && (32'(tag_rd[LVL_W-1:0]) <= 32'(TOP_LEVEL));
    stat.refill_last = cnt == '0;
    stat.clr_last    = clr_cnt == SLOT_W'(SLOTS - 1);
    stat.rsp_busy    = rsp_busy;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pages_enabled <= PAGES_ENABLED_RST;
      pages_used    <= '0;
      clr_cnt       <= '0;
      rsp_valid     <= 1'b0;
      for (int i = 0; i <= TOP_LEVEL; i++) heads[i] <= '0;
    end else begin
      if (cfg_we) pages_enabled <= cfg_data;
      if (cmd.clr_we) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.refill_push && stat.refill_last) pages_used <= pages_used + 1'b1;
      if (cmd.refill_push) heads[cur_lvl] <= '{valid: 1'b1, addr: blk};
      if (cmd.free_push) heads[cur_lvl] <= '{valid: 1'b1, addr: base};
      if (cmd.pop_commit) heads[cur_lvl] <= link_rd;
      if (cmd.rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // item and refill registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r  <= req.func;
      big     <= big_in;
      cur_lvl <= LVL_W'(lvl_in);
      base    <= fbase;
    end
    if (cmd.take_tag_lvl) cur_lvl <= tag_rd[LVL_W-1:0];
    if (cmd.pop_read) base <= head_cur.addr;
    if (cmd.refill_init) begin
      blk <= ADDR_W'(32'(pages_used) << PAGE_SHIFT);
      cnt <= CNT_W'((32'(PAGE_BYTES) >> cur_lvl) - 32'd1);
    end else if (cmd.refill_push) begin
      blk <= blk + ADDR_W'(32'd1 << cur_lvl);
      cnt <= cnt - 1'b1;
    end
    if (cmd.res_set) begin
      res.status     <= cmd.res_status;
      res.block_addr <= (cmd.res_status == STAT_OK && func_r == FUNC_ALLOC)
                      ? base + ADDR_W'(HEADER_BYTES) : '0;
    end
    if (cmd.rsp_load) rsp <= res;
  end

  // link memory
  always_ff @(posedge clk) begin
    if (cmd.refill_push) links[slot_blk] <= head_cur;
    else if (cmd.free_push) links[slot_base] <= head_cur;
    if (cmd.pop_read) link_rd <= links[slot_head];
  end

  // tag memory
  always_ff @(posedge clk) begin
    if (cmd.clr_we) tags[clr_cnt] <= '0;
    else if (cmd.pop_commit) tags[slot_base] <= {1'b1, cur_lvl};
    if (cmd.latch) tag_rd <= tags[slot_in];
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.rsp_load |-> !(rsp_valid && rsp_stall))
    else $error("result loaded over a stalled transfer");
  a_pop_head: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_read |-> head_cur.valid)
    else $error("pop from an empty class");
  a_push_lvl: assert property (@(posedge clk) disable iff (rst)
    cmd.free_push |-> (32'(cur_lvl) <= 32'(TOP_LEVEL)))
    else $error("free pushed to a class out of range");

endmodule

[rtl/size_class_block_allocator.sv]
// top level of the size class block allocator: controller plus datapath
// steps: allocate hit decode, pop, link, finish; free decode, free push, finish;
//   an allocate that refills adds PAGE_BYTES >> level pushes, one push per cycle
// throughput: one item at a time; the link and tag memory ports set the pop steps
// reset: synchronous; a clearing pass over POOL_PAGES*PAGE_BYTES/HEADER_BYTES slots
//   (16384 by default) sweeps the tag memory while req_stall stays high
module size_class_block_allocator import scba_pkg::*; #(
  parameter int POOL_PAGES   = POOL_PAGES_DEF,
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int TOP_LEVEL    = TOP_LEVEL_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // register writes are always taken; the user must write only while idle, not enforced
  assign cfg_ready = 1'b1;

  // controller sequences decode, refill, pop and free push steps
  scba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath holds heads, memories and the result register feeding rsp
  scba_dp #(
    .POOL_PAGES   (POOL_PAGES),
    .PAGE_BYTES   (PAGE_BYTES),
    .TOP_LEVEL    (TOP_LEVEL),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

[tb/sv/size_class_block_allocator_tb.sv]
// self-checking testbench for the size class block allocator
module size_class_block_allocator_tb;
  import scba_pkg::*;

  // block geometry, default parameters of the top level
  localparam int PAGE_SZ    = PAGE_BYTES_DEF;
  localparam int TOP_LVL    = TOP_LEVEL_DEF;
  localparam int HDR_SZ     = HEADER_BYTES_DEF;
  localparam int MIN_SHIFT  = 4;                 // log2 of the header size
  localparam int SLOT_CNT   = POOL_PAGES_DEF * PAGE_SZ / HDR_SZ;
  localparam int STALL_LIMIT = 80000;            // clearing pass after reset fits
  localparam int DIR_ROWS   = 19;

  typedef struct packed {
    logic              func;
    logic [REQ_W-1:0]  req_size;
    logic [ADDR_W-1:0] free_addr;
    logic              typed;        // expected result given in the row
    logic [ADDR_W-1:0] exp_addr;
    logic [1:0]        exp_status;
  } dir_row_t;

  logic             clk;
  logic             rst;
  logic             req_valid;
  logic             req_stall;
  req_t             req;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  rsp_t             rsp;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  size_class_block_allocator dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // free lists, links and tags of the allocator as the predictor sees them
  link_t       class_head [TOP_LVL+1];
  link_t       block_link [SLOT_CNT];
  logic        tag_valid  [SLOT_CNT];
  logic [3:0]  tag_level  [SLOT_CNT];
  int          pages_taken;
  int          page_budget;

  rsp_t              pending_rsp [$];   // results still owed by the block
  logic [ADDR_W-1:0] live_blocks [$];   // payload addresses handed out
  logic [ADDR_W-1:0] freed_blocks [$];  // payload addresses given back

  int send_idle_pct, recv_idle_pct;
  int idle_cycles;
  int errors, n_items, n_rsp, n_ok, n_big, n_empty, n_bad;
  bit hold_req = 1'b0;
  bit hold_ack = 1'b0;
  int hold_cnt = 0;
  bit done;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic void push_free(int lvl, logic [ADDR_W-1:0] base);
    block_link[base >> MIN_SHIFT] = class_head[lvl];
    class_head[lvl].valid = 1'b1;
    class_head[lvl].addr  = base;
  endfunction

  // next result of the allocator for one item, updating the shadow state
  function automatic rsp_t alloc_free_result(req_t r);
    rsp_t              o;
    int                size, lvl, limit;
    logic [ADDR_W-1:0] base;
    int                slot;
    o.block_addr = '0;
    o.status     = STAT_OK;
    if (r.func == FUNC_ALLOC) begin
      size = int'(r.req_size) + HDR_SZ;
      lvl = 0;
      while (lvl < 31 && (1 << lvl) < size) lvl++;
      limit = (page_budget < POOL_PAGES_DEF) ? page_budget : POOL_PAGES_DEF;
      if (size > PAGE_SZ || lvl > TOP_LVL) begin
        o.status = STAT_BIG;
      end else if (!class_head[lvl].valid && pages_taken >= limit) begin
        o.status = STAT_EMPTY;
      end else begin
        // refill splits the next page, lowest block pushed first
        if (!class_head[lvl].valid) begin
          for (int i = 0; i < (PAGE_SZ >> lvl); i++)
            push_free(lvl, ADDR_W'(pages_taken * PAGE_SZ + (i << lvl)));
          pages_taken++;
        end
        base = class_head[lvl].addr;
        slot = base >> MIN_SHIFT;
        class_head[lvl] = block_link[slot];
        tag_valid[slot] = 1'b1;
        tag_level[slot] = 4'(lvl);
        o.block_addr = base + ADDR_W'(HDR_SZ);   // wraps modulo 2^18
      end
    end else begin
      base = r.free_addr - ADDR_W'(HDR_SZ);
      slot = base >> MIN_SHIFT;
      if (base[MIN_SHIFT-1:0] == '0 && tag_valid[slot])
        push_free(int'(tag_level[slot]), base);
      else
        o.status = STAT_BAD;
    end
    return o;
  endfunction

  // one request transfer; prediction taken at the accepting edge
  task automatic send_item(req_t r, bit typed, rsp_t typed_rsp);
    rsp_t p;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid = 1'b0;
      req = req_t'({$urandom, $urandom});
      @(negedge clk);
    end
    req_valid = 1'b1;
    req = r;
    do @(posedge clk); while (req_stall);
    p = alloc_free_result(r);
    pending_rsp.push_back(typed ? typed_rsp : p);
    if (r.func == FUNC_ALLOC && p.status == STAT_OK) live_blocks.push_back(p.block_addr);
    n_items++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    req_valid = 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  task automatic write_page_budget(logic [CFG_W-1:0] v);
    drain_results();
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    page_budget = int'(v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic req_t random_item();
    req_t r;
    int   k, pick;
    r = req_t'({$urandom, $urandom});
    k = $urandom_range(0, 99);
    if (k < 58) begin
      r.func = FUNC_ALLOC;
      pick = $urandom_range(0, 99);
      if (pick < 75)      r.req_size = REQ_W'($urandom_range(0, 240));
      else if (pick < 95) r.req_size = REQ_W'($urandom_range(0, 4080));
      else                r.req_size = REQ_W'($urandom_range(4081, 8191));
    end else begin
      r.func = FUNC_FREE;
      pick = $urandom_range(0, 99);
      if (pick < 72 && live_blocks.size() != 0) begin
        k = $urandom_range(0, live_blocks.size() - 1);
        r.free_addr = live_blocks[k];
        live_blocks.delete(k);
        freed_blocks.push_back(r.free_addr);
      end else if (pick < 82 && freed_blocks.size() != 0) begin
        // double free of a block given back earlier
        r.free_addr = freed_blocks[$urandom_range(0, freed_blocks.size() - 1)];
      end
    end
    return r;
  endfunction

  task automatic run_random(int count, bit with_pause, bit with_hold);
    rsp_t none;
    none = '0;
    for (int i = 0; i < count; i++) begin
      if (with_pause && i == count / 3) drain_results();
      if (with_hold && i == count / 2) hold_req = !hold_req;
      send_item(random_item(), 1'b0, none);
    end
  endtask

  // receiver stall pattern, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_cnt <= 400;
      hold_ack <= hold_req;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
    rsp_stall <= (hold_req != hold_ack) || hold_cnt > 1
              || ($urandom_range(0, 99) < recv_idle_pct);
  end

  // result checker and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT && !done) begin
        $display("%0t watchdog: nothing transferred for %0d cycles", $time, STALL_LIMIT);
        $display("** size_class_block_allocator: FAILED **");
        $finish;
      end
      if (rsp_valid && !rsp_stall) begin
        n_rsp++;
        if (pending_rsp.size() == 0) begin
          $display("%0t unexpected result addr %0d status %0d", $time,
                   rsp.block_addr, rsp.status);
          errors++;
        end else begin
          if (rsp.block_addr !== pending_rsp[0].block_addr) begin
            $display("%0t block_addr expected %0d actual %0d", $time,
                     pending_rsp[0].block_addr, rsp.block_addr);
            errors++;
          end
          if (rsp.status !== pending_rsp[0].status) begin
            $display("%0t status expected %0d actual %0d", $time,
                     pending_rsp[0].status, rsp.status);
            errors++;
          end
          case (pending_rsp[0].status)
            STAT_OK:    n_ok++;
            STAT_BIG:   n_big++;
            STAT_EMPTY: n_empty++;
            default:    n_bad++;
          endcase
          void'(pending_rsp.pop_front());
        end
      end
    end
  end

  initial begin
    dir_row_t dir_tab [DIR_ROWS];
    req_t     r;
    rsp_t     t;
    // directed rows run with a budget of two pages
    dir_tab = '{
      '{FUNC_ALLOC, 13'd0,    18'd0,      1'b1, 18'd4096, STAT_OK},
      '{FUNC_ALLOC, 13'd0,    18'd0,      1'b1, 18'd4080, STAT_OK},
      '{FUNC_ALLOC, 13'd4080, 18'd0,      1'b1, 18'd4112, STAT_OK},
      '{FUNC_ALLOC, 13'd4081, 18'd0,      1'b1, 18'd0,    STAT_BIG},
      '{FUNC_ALLOC, 13'd8191, 18'd262143, 1'b1, 18'd0,    STAT_BIG},
      '{FUNC_ALLOC, 13'd4000, 18'd0,      1'b1, 18'd0,    STAT_EMPTY},
      '{FUNC_FREE,  13'd0,    18'd4112,   1'b1, 18'd0,    STAT_OK},
      '{FUNC_ALLOC, 13'd4080, 18'd0,      1'b0, 18'd0,    STAT_OK},
      '{FUNC_FREE,  13'd8191, 18'd5,      1'b1, 18'd0,    STAT_BAD},
      '{FUNC_FREE,  13'd0,    18'd0,      1'b1, 18'd0,    STAT_BAD},
      '{FUNC_FREE,  13'd0,    18'd262143, 1'b1, 18'd0,    STAT_BAD},
      '{FUNC_FREE,  13'd0,    18'd4096,   1'b0, 18'd0,    STAT_OK},
      '{FUNC_FREE,  13'd0,    18'd4096,   1'b0, 18'd0,    STAT_OK},   // double free
      '{FUNC_ALLOC, 13'd0,    18'd0,      1'b0, 18'd0,    STAT_OK},
      '{FUNC_ALLOC, 13'd0,    18'd0,      1'b0, 18'd0,    STAT_OK},   // same block again
      '{FUNC_ALLOC, 13'd1,    18'd0,      1'b0, 18'd0,    STAT_OK},
      '{FUNC_ALLOC, 13'd100,  18'd0,      1'b0, 18'd0,    STAT_OK},
      '{FUNC_ALLOC, 13'd2032, 18'd0,      1'b0, 18'd0,    STAT_OK},
      '{FUNC_FREE,  13'd0,    18'd4080,   1'b0, 18'd0,    STAT_OK}
    };
    for (int i = 0; i <= TOP_LVL; i++) class_head[i] = '0;
    for (int i = 0; i < SLOT_CNT; i++) begin
      block_link[i] = '0;
      tag_valid[i]  = 1'b0;
      tag_level[i]  = '0;
    end
    pages_taken = 0;
    page_budget = int'(PAGES_ENABLED_RST);
    errors = 0; n_items = 0; n_rsp = 0;
    n_ok = 0; n_big = 0; n_empty = 0; n_bad = 0;
    idle_cycles = 0; done = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0; req = '0;
    cfg_valid = 1'b0; cfg_data = '0;
    send_idle_pct = 17; recv_idle_pct = 66;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part on a two page pool
    write_page_budget(7'd2);
    foreach (dir_tab[i]) begin
      r.func      = dir_tab[i].func;
      r.req_size  = dir_tab[i].req_size;
      r.free_addr = dir_tab[i].free_addr;
      t.block_addr = dir_tab[i].exp_addr;
      t.status     = dir_tab[i].exp_status;
      send_item(r, dir_tab[i].typed, t);
    end

    // random phases: full pool, a random budget, the smallest, then the full pool again
    write_page_budget(7'd64);
    run_random(280, 1'b1, 1'b0);
    send_idle_pct = 66; recv_idle_pct = 17;
    write_page_budget(CFG_W'($urandom_range(1, 63)));
    run_random(280, 1'b0, 1'b1);
    send_idle_pct = 0; recv_idle_pct = 0;
    write_page_budget(7'd1);
    run_random(130, 1'b0, 1'b0);
    write_page_budget(7'd64);
    run_random(140, 1'b0, 1'b0);

    drain_results();
    repeat (300) @(posedge clk);
    done = 1'b1;
    $display("run covered %0d items over four page budgets: %0d ok, %0d too big,",
             n_items, n_ok, n_big);
    $display("  %0d out of pages, %0d ignored frees, %0d pages split", n_empty, n_bad,
             pages_taken);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("** size_class_block_allocator: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results left over", errors, pending_rsp.size());
      $display("** size_class_block_allocator: FAILED **");
    end
    $finish;
  end

endmodule
